// ----- design/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Sizes, opcode and status codes, and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int CAPACITY = 1024;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_SIZE       = 3'd4,
		OP_CLEAR      = 3'd5,
		OP_PEEK_BACK  = 3'd6,
		OP_PEEK_FRONT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_VALUE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // word taken on the input side this cycle
		logic load_direct; // load output register from the decoded result
		logic load_read;   // load output register from the memory read data
	} dq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_read;  // current input word returns a stored element
	} dq_stat_t;

endpackage

// ----- design/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl: controller for the double-ended queue
// Sequences each word through decode and an optional memory read, owns out_valid.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dq_pkg::dq_stat_t stat,
	output dq_pkg::dq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.accept      = accept;
		cmd.load_direct = accept && !stat.needs_read;
		cmd.load_read   = (state_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && stat.needs_read) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_direct || cmd.load_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath: ring buffer storage, pointers and output register
// Decodes the opcode against the count, updates pointers, writes or reads memory.
// ----------------------------------------------------------------------------
module dq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [2:0]                          opcode,
	input  logic signed [dq_pkg::DATA_W-1:0]    push_value,
	input  dq_pkg::dq_cmd_t                     cmd,
	output dq_pkg::dq_stat_t                    stat,
	output logic [1:0]                          status,
	output logic signed [dq_pkg::DATA_W-1:0]    result_value,
	output logic [dq_pkg::CNT_W-1:0]            element_count
);

	localparam int PW = dq_pkg::PTR_W;
	localparam int CW = dq_pkg::CNT_W;
	localparam int DW = dq_pkg::DATA_W;

	logic [DW-1:0] mem [dq_pkg::CAPACITY];

	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	logic [PW-1:0] head_next, head_prev, tail_prev;
	logic [PW-1:0] wr_addr, rd_addr;
	logic          wr_en;
	logic          full, empty;
	dq_pkg::op_t     op;
	dq_pkg::status_t st_d;

	logic [DW-1:0]     rd_data_q;
	dq_pkg::status_t   status_q;
	logic [DW-1:0]     value_q;
	logic [CW-1:0]     count_out_q;

	assign op    = dq_pkg::op_t'(opcode);
	assign full  = (count_q == CW'(dq_pkg::CAPACITY));
	assign empty = (count_q == '0);

	// wrap pointers at the ring ends
	assign head_next = (head_q == PW'(dq_pkg::CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? PW'(dq_pkg::CAPACITY - 1) : head_q - 1'b1;
	assign tail_prev = (tail_q == '0) ? PW'(dq_pkg::CAPACITY - 1) : tail_q - 1'b1;

	always_comb begin
		head_d          = head_q;
		tail_d          = tail_q;
		count_d         = count_q;
		wr_en           = 1'b0;
		wr_addr         = tail_q;
		rd_addr         = head_q;
		st_d            = dq_pkg::ST_OK;
		stat.needs_read = 1'b0;
		case (op)
			dq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					st_d = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_q;
					tail_d  = (tail_q == PW'(dq_pkg::CAPACITY - 1)) ? '0 : tail_q + 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					st_d = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = head_prev;
					head_d  = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::OP_POP_BACK: begin
				if (empty) begin
					st_d = dq_pkg::ST_EMPTY;
				end else begin
					stat.needs_read = 1'b1;
					rd_addr         = tail_prev;
					tail_d          = tail_prev;
					count_d         = count_q - 1'b1;
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					st_d = dq_pkg::ST_EMPTY;
				end else begin
					stat.needs_read = 1'b1;
					rd_addr         = head_q;
					head_d          = head_next;
					count_d         = count_q - 1'b1;
				end
			end
			dq_pkg::OP_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			dq_pkg::OP_PEEK_BACK: begin
				if (empty) begin
					st_d = dq_pkg::ST_EMPTY;
				end else begin
					stat.needs_read = 1'b1;
					rd_addr         = tail_prev;
				end
			end
			dq_pkg::OP_PEEK_FRONT: begin
				if (empty) begin
					st_d = dq_pkg::ST_EMPTY;
				end else begin
					stat.needs_read = 1'b1;
					rd_addr         = head_q;
				end
			end
			default: begin
				st_d = dq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// single write, registered read; capture read data when the word is taken
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			mem[wr_addr] <= push_value;
		end
		if (cmd.accept) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			status_q    <= st_d;
			value_q     <= '0;
			count_out_q <= count_d;
		end else if (cmd.load_read) begin
			status_q    <= dq_pkg::ST_VALUE;
			value_q     <= rd_data_q;
			count_out_q <= count_q;
		end
	end

	assign status        = status_q;
	assign result_value  = value_q;
	assign element_count = count_out_q;

endmodule

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit words in a 1024-entry ring buffer
// Push, pop and peek at either end, size and clear; one result word per input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode and push_value. Output
//   channel (out_valid/out_ready) returns status, result_value and
//   element_count, one result word for every input word, in order.
//   Pushes, size, clear and any error present their result in the cycle
//   after the input word is taken. Pops and peeks of a non-empty queue
//   pass through the registered read port of the element memory first.
//   Throughput: one word per cycle for operations that read no element,
//   while the receiver keeps up; pops and peeks block input during the read.
//   The result sits in an output register; the next input word is taken in
//   the same cycle the waiting result leaves, so a stalled receiver stalls
//   the input only while the output register is full.
//   Reset (arst_n low) empties the queue: pointers and count go to zero and
//   no result is pending. The element memory is not cleared; the count
//   guards every read, so stale data never reaches the output.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       opcode,
	input  logic signed [dq_pkg::DATA_W-1:0] push_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic signed [dq_pkg::DATA_W-1:0] result_value,
	output logic [dq_pkg::CNT_W-1:0]         element_count
);

	dq_pkg::dq_cmd_t  cmd;
	dq_pkg::dq_stat_t stat;

	// sequence each word and own the output handshake
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage, pointers and result register
	dq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.push_value    (push_value),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.result_value  (result_value),
		.element_count (element_count)
	);

	// a word that reads no element shows its result on the next cycle
	a_direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !stat.needs_read |=> out_valid)
		else $error("direct result not presented");

	// a word that reads an element holds in_ready low in the cycle after it is taken, then presents its result
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && stat.needs_read |=> !in_ready ##1 out_valid)
		else $error("read sequencing broken");

	// reported count never exceeds the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> element_count <= dq_pkg::CNT_W'(dq_pkg::CAPACITY))
		else $error("element count out of range");

	// a returned element always carries the value status
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_read |=> status == dq_pkg::ST_VALUE)
		else $error("read result has wrong status");

endmodule
